// ===== rtl/core/tmtw_pkg.sv =====
`default_nettype none

package tmtw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int TAB_STOP       = 4;

    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W      = $clog2(SCREEN_ROWS);

    localparam logic [7:0]  RESET_ATTR  = 8'h07;
    localparam logic [15:0] RESET_BLANK = {RESET_ATTR, 8'h00};

    // control bytes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum logic {
        OP_PUT  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        op_t         opcode;
        logic [7:0]  char_byte;
        logic [10:0] cell_address;
    } cmd_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [10:0] cursor_index;
        logic        text_changed;
        logic        cursor_changed;
        logic        address_error;
    } result_t;

    // column after a tab, indexed by the current column
    typedef logic [COL_W:0] tab_col_t;
    typedef tab_col_t tab_tbl_t [SCREEN_COLUMNS];

    function automatic tab_tbl_t build_tab_table();
        tab_tbl_t t;
        for (int i = 0; i < SCREEN_COLUMNS; i++)
        begin
            t[i] = tab_col_t'(((i + TAB_STOP - 1) / TAB_STOP) * TAB_STOP);
        end
        return t;
    endfunction

    localparam tab_tbl_t TAB_TARGET = build_tab_table();

endpackage

`default_nettype wire

// ===== rtl/core/tmtw_ram.sv =====
`default_nettype none

module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/text_mode_terminal_writer.sv =====
`default_nettype none

// Text console writer: keeps an 80x25 screen of attribute/character cells in
// one block RAM plus a cursor. A command is taken when start is high and busy
// is low. Putting a character gives its result in the cycle after acceptance
// and busy stays low, so puts that do not scroll run at one per cycle; a cell
// read passes through the RAM read register and then the result register. A
// put that pushes the cursor past the last row scrolls: the RAM is walked one
// cell per cycle, with busy high, before that command's result appears. After
// reset the RAM is cleared one cell per cycle with busy high; attribute writes
// are taken at any time. Each result is shown on result for exactly one cycle
// with done high; the receiver cannot stall it.
module text_mode_terminal_writer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire tmtw_pkg::cmd_t   command,
    output logic                  done,
    output tmtw_pkg::result_t     result,
    input  wire logic             cfg_we,
    input  wire logic [7:0]       cfg_wdata
);

    import tmtw_pkg::*;

    localparam int CMP_W = (ADDR_W > 11) ? ADDR_W : 11;
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [7:0]        attr_reg;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;
    logic              pend_we_reg, pend_we_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              pend_blank_reg, pend_blank_next;

    logic              accept;
    logic              is_read;
    logic              addr_ok;
    logic              go_read;
    logic              go_scroll;
    logic              ptr_last;

    logic [COL_W:0]    col_t;
    logic [ROW_W:0]    row_t;
    logic [COL_W-1:0]  wcol;
    logic              put_we;
    logic [7:0]        put_char;
    logic              put_text;
    logic              put_cur;
    logic [ADDR_W-1:0] put_addr;
    logic [ADDR_W-1:0] new_index;
    logic [ADDR_W-1:0] cur_index;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    tmtw_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign is_read  = (command.opcode == OP_READ);
    assign addr_ok  = CMP_W'(command.cell_address) < CMP_W'(CELL_COUNT);
    assign go_read  = accept && is_read && addr_ok;
    assign ptr_last = (ptr_reg == LAST_CELL);

    // character decode and cursor update
    always_comb
    begin
        col_t    = {1'b0, col_reg};
        row_t    = {1'b0, row_reg};
        wcol     = col_reg;
        put_we   = 1'b0;
        put_char = command.char_byte;
        put_text = 1'b0;
        put_cur  = 1'b0;
        case (command.char_byte)
            CH_NUL, CH_BEL, CH_VT, CH_FF:
            begin
                put_cur = 1'b0;
            end
            CH_LF:
            begin
                row_t   = row_t + 1'b1;
                col_t   = '0;
                put_cur = 1'b1;
            end
            CH_CR:
            begin
                col_t   = '0;
                put_cur = 1'b1;
            end
            CH_TAB:
            begin
                if (TAB_TARGET[col_reg] != {1'b0, col_reg})
                begin
                    col_t   = TAB_TARGET[col_reg];
                    put_cur = 1'b1;
                end
            end
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    col_t   = {1'b0, col_reg} - 1'b1;
                    wcol    = col_reg - 1'b1;
                    put_cur = 1'b1;
                end
                put_we   = 1'b1;
                put_char = 8'h00;
                put_text = 1'b1;
            end
            default:
            begin
                col_t    = {1'b0, col_reg} + 1'b1;
                put_we   = 1'b1;
                put_text = 1'b1;
                put_cur  = 1'b1;
            end
        endcase

        if (col_t >= (COL_W+1)'(SCREEN_COLUMNS))
        begin
            col_t   = '0;
            row_t   = row_t + 1'b1;
            put_cur = 1'b1;
        end

        go_scroll = 1'b0;
        if (row_t >= (ROW_W+1)'(SCREEN_ROWS))
        begin
            row_t     = (ROW_W+1)'(SCREEN_ROWS - 1);
            put_text  = 1'b1;
            put_cur   = 1'b1;
            go_scroll = accept && !is_read;
        end

        put_addr  = ADDR_W'(row_reg) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(wcol);
        new_index = ADDR_W'(row_t[ROW_W-1:0]) * ADDR_W'(SCREEN_COLUMNS)
                  + ADDR_W'(col_t[COL_W-1:0]);
        cur_index = ADDR_W'(row_reg) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (ptr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (go_read)
                begin
                    state_next = ST_READ;
                end
                else if (go_scroll)
                begin
                    state_next = ST_COPY;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_COPY:
            begin
                if (ptr_last)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                if (ptr_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ptr_next        = ptr_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        pend_we_next    = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_blank_next = pend_blank_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_addr_reg;
        ram_wdata       = pend_blank_reg ? {attr_reg, 8'h00} : ram_rdata;
        ram_raddr       = ADDR_W'(command.cell_address);
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = RESET_BLANK;
                ptr_next  = ptr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next.cell_value     = '0;
                    result_next.cursor_index   = 11'(cur_index);
                    result_next.text_changed   = 1'b0;
                    result_next.cursor_changed = 1'b0;
                    result_next.address_error  = is_read && !addr_ok;
                    if (!is_read)
                    begin
                        result_next.cursor_index   = 11'(new_index);
                        result_next.text_changed   = put_text;
                        result_next.cursor_changed = put_cur;
                        row_next  = row_t[ROW_W-1:0];
                        col_next  = col_t[COL_W-1:0];
                        ram_we    = put_we;
                        ram_waddr = put_addr;
                        ram_wdata = {attr_reg, put_char};
                    end
                    done_next = !go_read && !go_scroll;
                    ptr_next  = ADDR_W'(SCREEN_COLUMNS);
                end
            end
            ST_READ:
            begin
                result_next.cell_value = ram_rdata;
                done_next = 1'b1;
            end
            ST_COPY:
            begin
                // read one row below, write back in the next cycle
                ram_we          = pend_we_reg;
                ram_raddr       = ptr_reg;
                pend_we_next    = 1'b1;
                pend_addr_next  = ptr_reg - ADDR_W'(SCREEN_COLUMNS);
                pend_blank_next = 1'b0;
                ptr_next        = ptr_last ? BOTTOM_ROW : ptr_reg + 1'b1;
            end
            ST_BLANK:
            begin
                ram_we          = pend_we_reg;
                pend_we_next    = 1'b1;
                pend_addr_next  = ptr_reg;
                pend_blank_next = 1'b1;
                ptr_next        = ptr_reg + 1'b1;
            end
            ST_FLUSH:
            begin
                ram_we    = pend_we_reg;
                done_next = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            ptr_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            attr_reg    <= RESET_ATTR;
            done_reg    <= 1'b0;
            pend_we_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            done_reg    <= done_next;
            pend_we_reg <= pend_we_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg     <= result_next;
        pend_addr_reg  <= pend_addr_next;
        pend_blank_reg <= pend_blank_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // every accepted transaction either answers next cycle or holds busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done || busy))
        else $error("accepted transaction neither answered nor busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(row_reg) < SCREEN_ROWS) && (int'(col_reg) < SCREEN_COLUMNS))
        else $error("cursor outside the screen");

    a_pending_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        pend_we_reg |-> (state_reg == ST_COPY || state_reg == ST_BLANK
                         || state_reg == ST_FLUSH))
        else $error("pending scroll write outside a scroll");

endmodule

`default_nettype wire
